@@ rtl/mrsa_pkg.sv @@
// Shared types, codes and the status-length table for the MIDI running-status assembler.
// Used by every module under rtl/. No dependencies.
`default_nettype none

package mrsa_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 32;
  localparam int SYSEX_MIN            = 4;

  localparam logic [7:0] ST_NONE   = 8'h00;
  localparam logic [7:0] ST_SYSEX  = 8'hF0;
  localparam logic [7:0] ST_TUNE   = 8'hF6;
  localparam logic [7:0] ST_EOX    = 8'hF7;
  localparam logic [7:0] ST_RT_MIN = 8'hF8;

  typedef enum logic [1:0] {
    KIND_RT    = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_SYSEX = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_SHORT_SYSEX = 2'd1,
    ERR_INTERRUPTED = 2'd2,
    ERR_BUF_FULL    = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    CLS_RT     = 2'd0,
    CLS_STATUS = 2'd1,
    CLS_DATA   = 2'd2
  } cls_t;

  // classified word passed from front to back
  typedef struct packed {
    cls_t       cls;
    logic [7:0] data;
    logic       is_eox;
    logic       len_one;
  } cmd_t;

  // one result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] status;
    logic [7:0] first;
    logic [7:0] second;
    logic [1:0] count;
    logic       last;
    err_t       err;
  } res_t;

  // message length including status; 0 = never completes
  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    len = 2'd0;
    if (s >= 8'h80 && s <= 8'hBF) len = 2'd3;
    else if (s >= 8'hC0 && s <= 8'hDF) len = 2'd2;
    else if (s >= 8'hE0 && s <= 8'hEF) len = 2'd3;
    else if (s == 8'hF1 || s == 8'hF3) len = 2'd2;
    else if (s == 8'hF2) len = 2'd3;
    else if (s == ST_TUNE) len = 2'd1;
    return len;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mrsa_front.sv @@
// Input side: takes raw MIDI bytes and classifies them into command words.
// Depends on mrsa_pkg.
`default_nettype none

module mrsa_front (
  input  wire logic             push,
  input  wire logic [7:0]       byte_in,
  output logic                  full,
  input  wire logic             fifo_full,
  output logic                  cmd_push,
  output mrsa_pkg::cmd_t        cmd
);

  assign full     = fifo_full;
  assign cmd_push = push && !fifo_full;

  always_comb begin
    if (byte_in >= mrsa_pkg::ST_RT_MIN) begin
      cmd.cls = mrsa_pkg::CLS_RT;
    end else if (byte_in[7]) begin
      cmd.cls = mrsa_pkg::CLS_STATUS;
    end else begin
      cmd.cls = mrsa_pkg::CLS_DATA;
    end
    cmd.data    = byte_in;
    cmd.is_eox  = (byte_in == mrsa_pkg::ST_EOX);
    cmd.len_one = (mrsa_pkg::msg_len(byte_in) == 2'd1);
  end

endmodule

`default_nettype wire

@@ rtl/mrsa_cmd_fifo.sv @@
// Two-entry queue of command words between the front and back sections.
// Depends on mrsa_pkg.
`default_nettype none

module mrsa_cmd_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire mrsa_pkg::cmd_t   wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output mrsa_pkg::cmd_t        rd_data,
  output logic                  valid
);

  mrsa_pkg::cmd_t q [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;

  assign full    = (fill == 2'd2);
  assign valid   = (fill != 2'd0);
  assign rd_data = q[rp];

  always_ff @(posedge clk) begin
    if (wr_en) q[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/mrsa_back.sv @@
// Execution side: running status, sysex buffer, message assembly and the result register.
// Depends on mrsa_pkg.
`default_nettype none

module mrsa_back #(
  parameter int BUFFER_DEPTH = mrsa_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  input  wire mrsa_pkg::cmd_t   cmd,
  output logic                  cmd_pop,
  input  wire logic             res_pop,
  output logic                  res_valid,
  output mrsa_pkg::res_t        res
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EMIT = 4'b0100,
    S_TAIL = 4'b1000
  } state_t;

  function automatic mrsa_pkg::res_t mk_res(
    input mrsa_pkg::kind_t kind,
    input logic [7:0]      status,
    input logic [7:0]      first,
    input logic [7:0]      second,
    input logic [1:0]      count,
    input logic            last,
    input mrsa_pkg::err_t  err
  );
    mrsa_pkg::res_t r;
    r.kind   = kind;
    r.status = status;
    r.first  = first;
    r.second = second;
    r.count  = count;
    r.last   = last;
    r.err    = err;
    return r;
  endfunction

  state_t         state, state_next;
  logic [7:0]     rs, rs_next;
  logic [CW-1:0]  count, count_next;
  logic [7:0]     d0, d0_next;
  logic [7:0]     d1, d1_next;
  logic [AW-1:0]  ptr, ptr_next;
  logic [7:0]     b_hold, b_hold_next;
  logic           eox_hold, eox_hold_next;
  logic           tail_hold, tail_hold_next;
  mrsa_pkg::res_t res_next;
  logic           load;
  logic           out_free;
  logic           mem_we;
  logic           mem_re;
  logic [7:0]     rd_data;
  logic [1:0]     rs_len;
  logic           drain_end;
  logic           head_e1;
  logic           head_e2;

  logic [7:0] mem [BUFFER_DEPTH];

  assign out_free  = !res_valid || res_pop;
  assign cmd_pop   = (state == S_IDLE) && cmd_valid && out_free;
  assign rs_len    = mrsa_pkg::msg_len(rs);
  assign drain_end = (CW'(ptr) == count - CW'(1));
  assign head_e1   = (rs == mrsa_pkg::ST_SYSEX);
  assign head_e2   = (rs != mrsa_pkg::ST_SYSEX) && (count != '0);

  always_comb begin
    state_next     = state;
    rs_next        = rs;
    count_next     = count;
    d0_next        = d0;
    d1_next        = d1;
    ptr_next       = ptr;
    b_hold_next    = b_hold;
    eox_hold_next  = eox_hold;
    tail_hold_next = tail_hold;
    res_next       = res;
    load           = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd_pop) begin
          case (cmd.cls)
            mrsa_pkg::CLS_RT: begin
              load     = 1'b1;
              res_next = mk_res(mrsa_pkg::KIND_RT, cmd.data, 8'h00, 8'h00, 2'd0, 1'b1,
                                mrsa_pkg::ERR_NONE);
            end
            mrsa_pkg::CLS_DATA: begin
              if (count >= CW'(BUFFER_DEPTH)) begin
                load     = 1'b1;
                res_next = mk_res(mrsa_pkg::KIND_ERROR, mrsa_pkg::ST_NONE, 8'h00, 8'h00,
                                  2'd0, 1'b1, mrsa_pkg::ERR_BUF_FULL);
              end else begin
                mem_we = 1'b1;
                if (count == CW'(0)) d0_next = cmd.data;
                if (count == CW'(1)) d1_next = cmd.data;
                if ((rs != mrsa_pkg::ST_SYSEX) &&
                    ((rs_len == 2'd2 && count == CW'(0)) ||
                     (rs_len == 2'd3 && count == CW'(1)))) begin
                  load       = 1'b1;
                  count_next = '0;
                  res_next   = mk_res(mrsa_pkg::KIND_SHORT, rs,
                                      (count == CW'(0)) ? cmd.data : d0,
                                      (count == CW'(1)) ? cmd.data : 8'h00,
                                      (count == CW'(0)) ? 2'd1 : 2'd2, 1'b1,
                                      mrsa_pkg::ERR_NONE);
                end else begin
                  count_next = count + CW'(1);
                end
              end
            end
            mrsa_pkg::CLS_STATUS: begin
              if (head_e1 && count >= CW'(mrsa_pkg::SYSEX_MIN)) begin
                // buffered sysex long enough: play it out byte by byte
                ptr_next       = '0;
                b_hold_next    = cmd.data;
                eox_hold_next  = cmd.is_eox;
                tail_hold_next = !cmd.is_eox && cmd.len_one;
                state_next     = S_READ;
              end else begin
                rs_next     = cmd.data;
                count_next  = '0;
                b_hold_next = cmd.data;
                if (head_e1 || head_e2) begin
                  load     = 1'b1;
                  res_next = mk_res(mrsa_pkg::KIND_ERROR, mrsa_pkg::ST_NONE, 8'h00, 8'h00,
                                    2'd0, !cmd.len_one,
                                    head_e1 ? mrsa_pkg::ERR_SHORT_SYSEX
                                            : mrsa_pkg::ERR_INTERRUPTED);
                  if (cmd.len_one) state_next = S_TAIL;
                end else if (cmd.len_one) begin
                  load     = 1'b1;
                  res_next = mk_res(mrsa_pkg::KIND_SHORT, cmd.data, 8'h00, 8'h00, 2'd0,
                                    1'b1, mrsa_pkg::ERR_NONE);
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        mem_re     = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load     = 1'b1;
          res_next = mk_res(mrsa_pkg::KIND_SYSEX, mrsa_pkg::ST_SYSEX, rd_data, 8'h00, 2'd0,
                            drain_end && !tail_hold, mrsa_pkg::ERR_NONE);
          if (drain_end) begin
            count_next = '0;
            rs_next    = eox_hold ? mrsa_pkg::ST_NONE : b_hold;
            state_next = tail_hold ? S_TAIL : S_IDLE;
          end else begin
            ptr_next   = ptr + AW'(1);
            state_next = S_READ;
          end
        end
      end
      S_TAIL: begin
        if (out_free) begin
          load       = 1'b1;
          res_next   = mk_res(mrsa_pkg::KIND_SHORT, b_hold, 8'h00, 8'h00, 2'd0, 1'b1,
                              mrsa_pkg::ERR_NONE);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sysex buffer
  always_ff @(posedge clk) begin
    if (mem_we) mem[count[AW-1:0]] <= cmd.data;
    if (mem_re) rd_data <= mem[ptr];
  end

  always_ff @(posedge clk) begin
    d0        <= d0_next;
    d1        <= d1_next;
    ptr       <= ptr_next;
    b_hold    <= b_hold_next;
    eox_hold  <= eox_hold_next;
    tail_hold <= tail_hold_next;
    res       <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rs        <= mrsa_pkg::ST_NONE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      rs    <= rs_next;
      count <= count_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/midi_running_status_assembler.sv @@
// MIDI running-status assembler, top level.
// Instantiates mrsa_front, mrsa_cmd_fifo and mrsa_back; depends on mrsa_pkg.
//
// Usage:
//  - Input queue: drive byte_in and raise push; a word is taken at a clock
//    edge with push high and full low. full rises when the two-word command
//    queue between the front and back sections is full.
//  - Result queue: while empty is low the oldest result sits on the result
//    ports; it is taken at an edge with pop high. A byte may cause no result
//    (buffered data) or several; the final one it causes carries last.
//  - Result path: with the back end idle and the result register free, a
//    taken byte is written into the queue and from there loads the result
//    register. Realtime bytes, short messages and errors load it straight
//    from the idle state; an error on a one-byte status adds that status.
//  - A sysex payload plays out of the single-port buffer byte by byte: each
//    byte is read (S_READ), then loaded into the result register (S_EMIT)
//    once it is free; no new byte is executed meanwhile, but up to two more
//    are taken into the queue.
//  - Stall: when the receiver holds pop low the result register keeps its
//    word, the back end waits, and the queue fills until full rises.
//  - Reset (rst, synchronous): clears running status and the fill count and
//    empties the queue and the result register. Buffer contents are not cleared; only
//    entries below the fill count are ever read.
`default_nettype none

module midi_running_status_assembler #(
  parameter int BUFFER_DEPTH = mrsa_pkg::DEFAULT_BUFFER_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire logic [7:0] byte_in,
  output logic            full,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      kind,
  output logic [7:0]      status_byte,
  output logic [7:0]      first_data,
  output logic [7:0]      second_data,
  output logic [1:0]      data_count,
  output logic            last,
  output logic [1:0]      error_code
);

  mrsa_pkg::cmd_t front_cmd;
  mrsa_pkg::cmd_t q_cmd;
  mrsa_pkg::res_t res;
  logic           cmd_push;
  logic           q_full;
  logic           q_valid;
  logic           cmd_pop;
  logic           res_valid;
  logic           res_pop;

  // front: classify each byte into a command word
  mrsa_front u_front (
    .push      (push),
    .byte_in   (byte_in),
    .full      (full),
    .fifo_full (q_full),
    .cmd_push  (cmd_push),
    .cmd       (front_cmd)
  );

  // short queue decoupling the two sections
  mrsa_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data (front_cmd),
    .full    (q_full),
    .rd_en   (cmd_pop),
    .rd_data (q_cmd),
    .valid   (q_valid)
  );

  // back: running status, buffer and result register
  mrsa_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_pop   (cmd_pop),
    .res_pop   (res_pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign empty   = !res_valid;
  assign res_pop = pop && res_valid;

  assign kind        = res.kind;
  assign status_byte = res.status;
  assign first_data  = res.first;
  assign second_data = res.second;
  assign data_count  = res.count;
  assign last        = res.last;
  assign error_code  = res.err;

endmodule

`default_nettype wire
